// ===== rtl/core/pjc_pkg.sv =====
// shared types and constants of the joint angle pid controller
`timescale 1ns / 1ps

package pjc_pkg;

    localparam int GAIN_W      = 24;
    localparam int DUTY_W      = 8;
    localparam int REQ_W       = 2;
    localparam int REG_IDX_W   = 3;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DUTY_W-1:0] SPEED_LIMIT_RESET = 8'd229;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TARGET = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SWAP   = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P_FIRST  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I_FIRST  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D_FIRST  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P_SECOND = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I_SECOND = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D_SECOND = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CAL_OFFSET    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd7;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_TARGET,
        KIND_SWAP
    } pjc_kind_t;

    localparam int KIND_W = 2;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } pjc_gains_t;

endpackage

// ===== rtl/core/pjc_queue.sv =====
// command queue between front and back
`timescale 1ns / 1ps

module pjc_queue
    import pjc_pkg::*;
#(
    parameter int WIDTH = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/pjc_front.sv =====
// front end: accepts words, calibrates the angle and forms the wrapped error
`timescale 1ns / 1ps

module pjc_front
    import pjc_pkg::*;
#(
    parameter int ANGLE_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [REQ_W-1:0]             req_type,
    input  logic [ANGLE_BITS-1:0]        target_angle,
    input  logic [ANGLE_BITS-1:0]        encoder_angle,
    input  logic                         encoder_valid,
    input  logic [ANGLE_BITS-1:0]        cal_offset,
    input  logic                         queue_full,
    output logic                         push,
    output pjc_kind_t                    push_kind,
    output logic [ANGLE_BITS-1:0]        push_angle,
    output logic signed [ANGLE_BITS:0]   push_err
);

    localparam int DIFF_W = ANGLE_BITS + 2;
    localparam logic signed [DIFF_W-1:0] HALF = DIFF_W'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [DIFF_W-1:0] TURN = DIFF_W'(1) <<< ANGLE_BITS;

    logic [ANGLE_BITS-1:0]     target_reg;
    logic [ANGLE_BITS-1:0]     held_angle_reg;
    logic [ANGLE_BITS-1:0]     cal_angle;
    logic [ANGLE_BITS-1:0]     angle;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  wrapped;
    logic                      accept;
    logic                      known_req;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign cal_angle = encoder_angle + cal_offset;
    assign angle     = encoder_valid ? cal_angle : held_angle_reg;
    assign diff      = $signed({2'b00, target_reg}) - $signed({2'b00, angle});

    always_comb
    begin
        wrapped = diff;
        if (diff > HALF)
        begin
            wrapped = diff - TURN;
        end
        else if (diff < -HALF)
        begin
            wrapped = diff + TURN;
        end
    end

    always_comb
    begin
        known_req = 1'b1;
        push_kind = KIND_TICK;
        unique case (req_type)
            REQ_TICK:   push_kind = KIND_TICK;
            REQ_TARGET: push_kind = KIND_TARGET;
            REQ_SWAP:   push_kind = KIND_SWAP;
            default:    known_req = 1'b0;
        endcase
    end

    assign push       = accept && known_req;
    assign push_angle = angle;
    assign push_err   = wrapped[ANGLE_BITS:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            held_angle_reg <= '0;
        end
        else if (accept)
        begin
            if (req_type == REQ_TARGET)
            begin
                target_reg <= target_angle;
            end
            if (req_type == REQ_TICK && encoder_valid)
            begin
                held_angle_reg <= cal_angle;
            end
        end
    end

endmodule

// ===== rtl/core/pjc_back.sv =====
// back end: error history, pid products, clamp and result register
`timescale 1ns / 1ps

module pjc_back
    import pjc_pkg::*;
#(
    parameter int ANGLE_BITS     = 14,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int SUM_BITS       = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         entry_valid,
    input  pjc_kind_t                    entry_kind,
    input  logic [ANGLE_BITS-1:0]        entry_angle,
    input  logic signed [ANGLE_BITS:0]   entry_err,
    output logic                         pop,
    input  pjc_gains_t                   gains_first,
    input  pjc_gains_t                   gains_second,
    input  logic [DUTY_W-1:0]            speed_limit,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DUTY_W-1:0]            pwm_duty,
    output logic                         drive_reverse,
    output logic [ANGLE_BITS-1:0]        joint_angle,
    output logic signed [ANGLE_BITS:0]   angle_error
);

    localparam int ERR_W   = ANGLE_BITS + 1;
    localparam int DELTA_W = ANGLE_BITS + 2;
    localparam int PP_W    = GAIN_W + ERR_W;
    localparam int PI_W    = GAIN_W + SUM_BITS;
    localparam int PD_W    = GAIN_W + DELTA_W;
    localparam int TOT_W   = PI_W + 2;
    localparam int MAG_W   = TOT_W - GAIN_FRAC_BITS;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS - 1){1'b0}}};

    logic adv;

    // history state
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic                       second_reg;

    // stage a
    logic                       a_valid_reg;
    logic [ANGLE_BITS-1:0]      a_angle_reg;
    logic signed [ERR_W-1:0]    a_err_reg;
    logic signed [SUM_BITS-1:0] a_sum_reg;
    logic signed [DELTA_W-1:0]  a_delta_reg;
    pjc_gains_t                 a_gains_reg;

    // stage b
    logic                       b_valid_reg;
    logic [ANGLE_BITS-1:0]      b_angle_reg;
    logic signed [ERR_W-1:0]    b_err_reg;
    logic signed [PP_W-1:0]     b_pp_reg;
    logic signed [PI_W-1:0]     b_pi_reg;
    logic signed [PD_W-1:0]     b_pd_reg;

    // stage c
    logic                       c_valid_reg;
    logic [ANGLE_BITS-1:0]      c_angle_reg;
    logic signed [ERR_W-1:0]    c_err_reg;
    logic signed [TOT_W-1:0]    c_total_reg;

    // result register
    logic                       d_valid_reg;
    logic [DUTY_W-1:0]          d_duty_reg;
    logic                       d_rev_reg;
    logic [ANGLE_BITS-1:0]      d_angle_reg;
    logic signed [ERR_W-1:0]    d_err_reg;

    logic signed [SUM_BITS:0]   sum_wide;
    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [DELTA_W-1:0]  delta_next;
    logic signed [PP_W-1:0]     pp_next;
    logic signed [PI_W-1:0]     pi_next;
    logic signed [PD_W-1:0]     pd_next;
    logic signed [TOT_W-1:0]    total_next;
    logic [TOT_W-1:0]           mag_full;
    logic [MAG_W-1:0]           mag;
    logic [DUTY_W-1:0]          duty_next;
    logic                       tick;

    assign adv  = !d_valid_reg || out_ready;
    assign pop  = entry_valid && adv;
    assign tick = pop && (entry_kind == KIND_TICK);

    // saturating error sum
    assign sum_wide = (SUM_BITS + 1)'(sum_reg) + (SUM_BITS + 1)'(entry_err);

    always_comb
    begin
        sum_next = sum_wide[SUM_BITS-1:0];
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
    end

    assign delta_next = DELTA_W'(entry_err) - DELTA_W'(prev_err_reg);

    assign pp_next    = a_gains_reg.kp * a_err_reg;
    assign pi_next    = a_gains_reg.ki * a_sum_reg;
    assign pd_next    = a_gains_reg.kd * a_delta_reg;
    assign total_next = TOT_W'(b_pp_reg) + TOT_W'(b_pi_reg) + TOT_W'(b_pd_reg);

    assign mag_full = c_total_reg[TOT_W-1] ? TOT_W'(-c_total_reg) : TOT_W'(c_total_reg);
    assign mag      = mag_full[TOT_W-1:GAIN_FRAC_BITS];
    assign duty_next = (mag > MAG_W'(speed_limit)) ? speed_limit : mag[DUTY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            prev_err_reg <= '0;
            second_reg   <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= tick;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            if (pop)
            begin
                case (entry_kind)
                    KIND_TARGET:
                    begin
                        sum_reg      <= '0;
                        prev_err_reg <= '0;
                    end
                    KIND_SWAP:
                    begin
                        second_reg <= !second_reg;
                    end
                    default:
                    begin
                        sum_reg      <= sum_next;
                        prev_err_reg <= entry_err;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_angle_reg <= entry_angle;
            a_err_reg   <= entry_err;
            a_sum_reg   <= sum_next;
            a_delta_reg <= delta_next;
            a_gains_reg <= second_reg ? gains_second : gains_first;

            b_angle_reg <= a_angle_reg;
            b_err_reg   <= a_err_reg;
            b_pp_reg    <= pp_next;
            b_pi_reg    <= pi_next;
            b_pd_reg    <= pd_next;

            c_angle_reg <= b_angle_reg;
            c_err_reg   <= b_err_reg;
            c_total_reg <= total_next;

            d_duty_reg  <= duty_next;
            d_rev_reg   <= c_total_reg[TOT_W-1] && (duty_next != '0);
            d_angle_reg <= c_angle_reg;
            d_err_reg   <= c_err_reg;
        end
    end

    assign out_valid     = d_valid_reg;
    assign pwm_duty      = d_duty_reg;
    assign drive_reverse = d_rev_reg;
    assign joint_angle   = d_angle_reg;
    assign angle_error   = d_err_reg;

    a_target_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && entry_kind == KIND_TARGET |=> sum_reg == '0 && prev_err_reg == '0)
        else $error("history not cleared on new target");

    a_swap_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        pop && entry_kind == KIND_SWAP |=> second_reg != $past(second_reg))
        else $error("gain set did not toggle");

    a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && $stable(speed_limit) |-> d_duty_reg <= speed_limit)
        else $error("duty above speed limit");

    a_reverse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && d_rev_reg |-> d_duty_reg != '0)
        else $error("reverse flagged with zero duty");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !out_ready |=> $stable(sum_reg) && $stable(c_total_reg))
        else $error("pipeline moved while stalled");

endmodule

// ===== rtl/core/pid_joint_angle_controller_top.sv =====
// top level of the joint angle pid controller with its register block
//
// channel   direction  handshake                 word
// in        input      in_valid / in_ready       req_type, target_angle, encoder_*
// out       output     out_valid / out_ready     pwm_duty, drive_reverse, joint_angle, angle_error
// apb       input      psel/penable/pwrite/pready  8 registers at 4*i
//
// one word per cycle while the queue is not full; an accepted tick enters the queue,
// which hands it to the four-stage back pipeline (sum, multiply, add, clamp) as it advances
// the 4-word queue keeps taking words while a result waits on out_ready
// a stalled output freezes the back pipeline; the front stalls only when the queue is full
// reset clears control state and registers (speed limit to 229) at once, no clearing pass
`timescale 1ns / 1ps

module pid_joint_angle_controller_top
    import pjc_pkg::*;
#(
    parameter int ANGLE_BITS     = 14,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int SUM_BITS       = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [REQ_W-1:0]             req_type,
    input  logic [ANGLE_BITS-1:0]        target_angle,
    input  logic [ANGLE_BITS-1:0]        encoder_angle,
    input  logic                         encoder_valid,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DUTY_W-1:0]            pwm_duty,
    output logic                         drive_reverse,
    output logic [ANGLE_BITS-1:0]        joint_angle,
    output logic signed [ANGLE_BITS:0]   angle_error,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready
);

    localparam int QW = KIND_W + ANGLE_BITS + ANGLE_BITS + 1;

    pjc_gains_t                 gains_first_reg;
    pjc_gains_t                 gains_second_reg;
    logic [ANGLE_BITS-1:0]      cal_offset_reg;
    logic [DUTY_W-1:0]          speed_limit_reg;
    logic [REG_IDX_W-1:0]       reg_idx;
    logic                       reg_write;

    logic                       q_full;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_not_empty;
    logic [QW-1:0]              q_head;
    pjc_kind_t                  push_kind;
    logic [ANGLE_BITS-1:0]      push_angle;
    logic signed [ANGLE_BITS:0] push_err;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_first_reg  <= '0;
            gains_second_reg <= '0;
            cal_offset_reg   <= '0;
            speed_limit_reg  <= SPEED_LIMIT_RESET;
        end
        else if (reg_write)
        begin
            unique case (reg_idx)
                REG_GAIN_P_FIRST:  gains_first_reg.kp  <= pwdata[GAIN_W-1:0];
                REG_GAIN_I_FIRST:  gains_first_reg.ki  <= pwdata[GAIN_W-1:0];
                REG_GAIN_D_FIRST:  gains_first_reg.kd  <= pwdata[GAIN_W-1:0];
                REG_GAIN_P_SECOND: gains_second_reg.kp <= pwdata[GAIN_W-1:0];
                REG_GAIN_I_SECOND: gains_second_reg.ki <= pwdata[GAIN_W-1:0];
                REG_GAIN_D_SECOND: gains_second_reg.kd <= pwdata[GAIN_W-1:0];
                REG_CAL_OFFSET:    cal_offset_reg      <= pwdata[ANGLE_BITS-1:0];
                REG_SPEED_LIMIT:   speed_limit_reg     <= pwdata[DUTY_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN_P_FIRST:  prdata = PDATA_W'(gains_first_reg.kp);
            REG_GAIN_I_FIRST:  prdata = PDATA_W'(gains_first_reg.ki);
            REG_GAIN_D_FIRST:  prdata = PDATA_W'(gains_first_reg.kd);
            REG_GAIN_P_SECOND: prdata = PDATA_W'(gains_second_reg.kp);
            REG_GAIN_I_SECOND: prdata = PDATA_W'(gains_second_reg.ki);
            REG_GAIN_D_SECOND: prdata = PDATA_W'(gains_second_reg.kd);
            REG_CAL_OFFSET:    prdata = PDATA_W'(cal_offset_reg);
            REG_SPEED_LIMIT:   prdata = PDATA_W'(speed_limit_reg);
            default:           prdata = '0;
        endcase
    end

    pjc_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .target_angle  (target_angle),
        .encoder_angle (encoder_angle),
        .encoder_valid (encoder_valid),
        .cal_offset    (cal_offset_reg),
        .queue_full    (q_full),
        .push          (q_push),
        .push_kind     (push_kind),
        .push_angle    (push_angle),
        .push_err      (push_err)
    );

    pjc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_kind, push_angle, push_err}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    pjc_back #(
        .ANGLE_BITS     (ANGLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_BITS       (SUM_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_valid   (q_not_empty),
        .entry_kind    (pjc_kind_t'(q_head[QW-1 -: KIND_W])),
        .entry_angle   (q_head[2*ANGLE_BITS:ANGLE_BITS+1]),
        .entry_err     ($signed(q_head[ANGLE_BITS:0])),
        .pop           (q_pop),
        .gains_first   (gains_first_reg),
        .gains_second  (gains_second_reg),
        .speed_limit   (speed_limit_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pwm_duty      (pwm_duty),
        .drive_reverse (drive_reverse),
        .joint_angle   (joint_angle),
        .angle_error   (angle_error)
    );

endmodule
